// ===== rtl/rgb2hsv_pkg.sv =====
// Shared types and constants for the RGB to HSV pixel converter.
// Depends on nothing; imported by rgb_to_hsv_convert and its testbench.
`timescale 1ns / 1ps

package rgb2hsv_pkg;

    // Component and field widths
    localparam int COMP_W   = 8;
    localparam int ALPHA_W  = 8;
    localparam int HUE_FRAC = 6;
    localparam int HUE_W    = 15;

    // Full-scale component, 60 degrees and 360 degrees in hue units
    localparam int FULL_SCALE = (1 << COMP_W) - 1;
    localparam int HUE_UNIT   = 60 << HUE_FRAC;
    localparam int HUE_CIRCLE = 360 << HUE_FRAC;
    localparam int HUE_UNIT_W = $clog2(HUE_UNIT + 1);

    // Divider sizing: quotient bits cover both hue fraction and saturation,
    // remainder bits cover the divisor shifted by the top quotient bit.
    localparam int QUO_W = (HUE_UNIT_W > COMP_W) ? HUE_UNIT_W : COMP_W;
    localparam int DIV_W = COMP_W + QUO_W;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    typedef struct packed {
        logic [COMP_W-1:0]  red_in;
        logic [COMP_W-1:0]  green_in;
        logic [COMP_W-1:0]  blue_in;
        logic [ALPHA_W-1:0] alpha_in;
    } rgb_pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]   hue_out;
        logic [COMP_W-1:0]  saturation_out;
        logic [COMP_W-1:0]  value_out;
        logic [ALPHA_W-1:0] alpha_out;
    } hsv_pixel_t;

    // First stage: extremes and the signed difference for the hue sector
    typedef struct packed {
        logic [COMP_W-1:0]  vmax;
        logic [COMP_W-1:0]  vmin;
        logic [COMP_W-1:0]  absdiff;
        logic               neg;
        sector_t            sector;
        logic [ALPHA_W-1:0] alpha;
    } front_t;

    // Divider stages: two restoring divisions side by side
    typedef struct packed {
        logic [DIV_W-1:0]   hue_rem;
        logic [DIV_W-1:0]   sat_rem;
        logic [QUO_W-1:0]   hue_quo;
        logic [QUO_W-1:0]   sat_quo;
        logic [COMP_W-1:0]  delta;
        logic [COMP_W-1:0]  vmax;
        logic               neg;
        sector_t            sector;
        logic [ALPHA_W-1:0] alpha;
    } div_t;

endpackage

// ===== rtl/rgb_to_hsv_convert.sv =====
// RGB to HSV pixel converter, fully pipelined.
// Depends on rgb2hsv_pkg.
`timescale 1ns / 1ps

// Converts one RGBA pixel per clock, while hsv_stall is low, into hue (1/64
// degree units), saturation, value and pass-through alpha. The pipeline runs
// through a front stage, a restoring divider that retires one quotient bit per
// stage for hue and saturation in parallel, and an output stage. Each
// stage holds while the stage after it is full and stalled, so bubbles are
// squeezed out and a stall loses or repeats nothing. No state links pixels.
module rgb_to_hsv_convert (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rgb_valid,
    output logic                    rgb_stall,
    input  rgb2hsv_pkg::rgb_pixel_t rgb,
    output logic                    hsv_valid,
    input  logic                    hsv_stall,
    output rgb2hsv_pkg::hsv_pixel_t hsv
);
    import rgb2hsv_pkg::*;

    front_t     front_next;
    front_t     front_reg;
    logic       front_valid_reg;
    logic       front_en;

    div_t       div_next  [0:QUO_W];
    div_t       div_reg   [0:QUO_W];
    logic [QUO_W:0] div_valid_reg;
    logic [QUO_W:0] div_en;

    hsv_pixel_t out_next;
    hsv_pixel_t out_reg;
    logic       out_valid_reg;
    logic       out_en;

    logic [COMP_W-1:0] diff_a;
    logic [COMP_W-1:0] diff_b;
    logic [HUE_W-1:0]  hue_q;

    // Stage advance chain: a stage loads when empty or when its successor moves
    always_comb
    begin
        out_en = !out_valid_reg || !hsv_stall;
        div_en[QUO_W] = !div_valid_reg[QUO_W] || out_en;
        for (int k = QUO_W - 1; k >= 0; k--)
        begin
            div_en[k] = !div_valid_reg[k] || div_en[k+1];
        end
        front_en = !front_valid_reg || div_en[0];
    end

    assign rgb_stall = !front_en;
    assign hsv_valid = out_valid_reg;
    assign hsv       = out_reg;

    // Front: max, min, sector by priority red/green/blue, and |difference|
    always_comb
    begin
        front_next.alpha = rgb.alpha_in;
        if (rgb.red_in >= rgb.green_in && rgb.red_in >= rgb.blue_in)
        begin
            front_next.sector = SECTOR_RED;
            front_next.vmax   = rgb.red_in;
            diff_a            = rgb.green_in;
            diff_b            = rgb.blue_in;
        end
        else if (rgb.green_in >= rgb.blue_in)
        begin
            front_next.sector = SECTOR_GREEN;
            front_next.vmax   = rgb.green_in;
            diff_a            = rgb.blue_in;
            diff_b            = rgb.red_in;
        end
        else
        begin
            front_next.sector = SECTOR_BLUE;
            front_next.vmax   = rgb.blue_in;
            diff_a            = rgb.red_in;
            diff_b            = rgb.green_in;
        end
        front_next.vmin = rgb.red_in;
        if (rgb.green_in < front_next.vmin)
        begin
            front_next.vmin = rgb.green_in;
        end
        if (rgb.blue_in < front_next.vmin)
        begin
            front_next.vmin = rgb.blue_in;
        end
        front_next.neg     = diff_a < diff_b;
        front_next.absdiff = front_next.neg ? (diff_b - diff_a) : (diff_a - diff_b);
    end

    // Numerators: 60 degrees times |difference|, full scale times delta
    always_comb
    begin
        div_next[0].delta   = front_reg.vmax - front_reg.vmin;
        div_next[0].vmax    = front_reg.vmax;
        div_next[0].neg     = front_reg.neg;
        div_next[0].sector  = front_reg.sector;
        div_next[0].alpha   = front_reg.alpha;
        div_next[0].hue_rem = DIV_W'(front_reg.absdiff) * DIV_W'(HUE_UNIT);
        div_next[0].sat_rem = DIV_W'(div_next[0].delta) * DIV_W'(FULL_SCALE);
        div_next[0].hue_quo = '0;
        div_next[0].sat_quo = '0;
    end

    // Restoring divider: one quotient bit per stage, most significant first
    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_div
        localparam int BIT = QUO_W - k;
        logic [DIV_W-1:0] hue_sub;
        logic [DIV_W-1:0] sat_sub;

        always_comb
        begin
            hue_sub     = DIV_W'(div_reg[k-1].delta) << BIT;
            sat_sub     = DIV_W'(div_reg[k-1].vmax) << BIT;
            div_next[k] = div_reg[k-1];
            if (div_reg[k-1].hue_rem >= hue_sub)
            begin
                div_next[k].hue_rem      = div_reg[k-1].hue_rem - hue_sub;
                div_next[k].hue_quo[BIT] = 1'b1;
            end
            if (div_reg[k-1].sat_rem >= sat_sub)
            begin
                div_next[k].sat_rem      = div_reg[k-1].sat_rem - sat_sub;
                div_next[k].sat_quo[BIT] = 1'b1;
            end
        end
    end

    // Output: place the hue fraction in its sector, clear grey and black cases
    always_comb
    begin
        hue_q = HUE_W'(div_reg[QUO_W].hue_quo);
        out_next.value_out = div_reg[QUO_W].vmax;
        out_next.alpha_out = div_reg[QUO_W].alpha;
        case (div_reg[QUO_W].sector)
            SECTOR_RED:
            begin
                if (!div_reg[QUO_W].neg)
                begin
                    out_next.hue_out = hue_q;
                end
                else if (hue_q == '0)
                begin
                    out_next.hue_out = '0;
                end
                else
                begin
                    out_next.hue_out = HUE_W'(HUE_CIRCLE) - hue_q;
                end
            end
            SECTOR_GREEN:
            begin
                out_next.hue_out = div_reg[QUO_W].neg ? HUE_W'(2 * HUE_UNIT) - hue_q
                                                      : HUE_W'(2 * HUE_UNIT) + hue_q;
            end
            SECTOR_BLUE:
            begin
                out_next.hue_out = div_reg[QUO_W].neg ? HUE_W'(4 * HUE_UNIT) - hue_q
                                                      : HUE_W'(4 * HUE_UNIT) + hue_q;
            end
            default:
            begin
                out_next.hue_out = '0;
            end
        endcase
        if (div_reg[QUO_W].delta == '0)
        begin
            out_next.hue_out = '0;
        end
        out_next.saturation_out = (div_reg[QUO_W].vmax == '0) ? '0
                                : div_reg[QUO_W].sat_quo[COMP_W-1:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
            div_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (front_en)
            begin
                front_valid_reg <= rgb_valid;
            end
            if (div_en[0])
            begin
                div_valid_reg[0] <= front_valid_reg;
            end
            for (int k = 1; k <= QUO_W; k++)
            begin
                if (div_en[k])
                begin
                    div_valid_reg[k] <= div_valid_reg[k-1];
                end
            end
            if (out_en)
            begin
                out_valid_reg <= div_valid_reg[QUO_W];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            front_reg <= front_next;
        end
        for (int k = 0; k <= QUO_W; k++)
        begin
            if (div_en[k])
            begin
                div_reg[k] <= div_next[k];
            end
        end
        if (out_en)
        begin
            out_reg <= out_next;
        end
    end

    // A free output side never blocks the input side
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !hsv_stall |-> !rgb_stall)
        else $error("input stalled while output side is free");

    // Zero saturation only for grey pixels, which have zero hue
    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hsv.saturation_out == '0 |-> hsv.hue_out == '0)
        else $error("nonzero hue on grey pixel");

    // Hue stays below a full circle
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> hsv.hue_out < HUE_W'(HUE_CIRCLE))
        else $error("hue out of range");

endmodule

// ===== test/tb_rgb_to_hsv_convert.sv =====
// Self-checking testbench for the rgb_to_hsv_convert pixel converter.
// Depends on rgb2hsv_pkg and rgb_to_hsv_convert; predicts every HSV pixel in a scoreboard.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_convert;

    import rgb2hsv_pkg::*;

    localparam int DIRECTED_COUNT = 21;
    localparam int RANDOM_COUNT   = 1030;
    localparam int IDLE_LIMIT     = 2000;   // cycles with no request accepted on either side
    localparam int HOLD_CYCLES    = 60;     // long receiver hold-off, well past pipeline depth
    localparam int TAIL_CYCLES    = 20;     // idle tail after the final drain
    localparam int MAX_PRINTS     = 100;

    // Hue scale: 60 degrees and a full circle in 1/64 degree steps
    localparam int DEG60_UNITS  = 60 << HUE_FRAC;
    localparam int CIRCLE_UNITS = 360 << HUE_FRAC;

    // Expected HSV pixels, in request order, with the RGB pixel that caused each
    class hsv_scoreboard;
        hsv_pixel_t expected_q[$];
        rgb_pixel_t source_q[$];
        int         errors;
        int         checked;
        int         grey_hits;
        int         sector_hits[3];

        function hsv_pixel_t convert_pixel(rgb_pixel_t p);
            int         r, g, b, mx, mn, delta, hue, sat;
            hsv_pixel_t h;
            r = p.red_in;
            g = p.green_in;
            b = p.blue_in;
            mx = (r > g) ? r : g;
            mx = (b > mx) ? b : mx;
            mn = (r < g) ? r : g;
            mn = (b < mn) ? b : mn;
            delta = mx - mn;
            hue = 0;
            sat = 0;
            // sector priority red, green, blue; integer divide truncates toward zero
            if (delta == 0)
            begin
                grey_hits++;
            end
            else if (mx == r)
            begin
                hue = (DEG60_UNITS * (g - b)) / delta;
                if (hue < 0)
                    hue += CIRCLE_UNITS;
                sector_hits[SECTOR_RED]++;
            end
            else if (mx == g)
            begin
                hue = 2 * DEG60_UNITS + (DEG60_UNITS * (b - r)) / delta;
                sector_hits[SECTOR_GREEN]++;
            end
            else
            begin
                hue = 4 * DEG60_UNITS + (DEG60_UNITS * (r - g)) / delta;
                sector_hits[SECTOR_BLUE]++;
            end
            if (mx != 0)
                sat = (FULL_SCALE * delta) / mx;
            h.hue_out        = hue[HUE_W-1:0];
            h.saturation_out = sat[COMP_W-1:0];
            h.value_out      = mx[COMP_W-1:0];
            h.alpha_out      = p.alpha_in;
            return h;
        endfunction

        function void note_pixel(rgb_pixel_t p);
            expected_q.push_back(convert_pixel(p));
            source_q.push_back(p);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_pixel(hsv_pixel_t got);
            hsv_pixel_t want;
            rgb_pixel_t src;
            string      tag;
            if (expected_q.size() == 0)
            begin
                report($sformatf("output with nothing expected: hue %0d sat %0d val %0d a %0d",
                                 got.hue_out, got.saturation_out, got.value_out,
                                 got.alpha_out));
                return;
            end
            want = expected_q.pop_front();
            src  = source_q.pop_front();
            tag  = $sformatf("pixel %0d rgba(%0d,%0d,%0d,%0d)", checked, src.red_in,
                             src.green_in, src.blue_in, src.alpha_in);
            checked++;
            if (got.hue_out !== want.hue_out)
                report($sformatf("%s hue %0d, want %0d", tag, got.hue_out, want.hue_out));
            if (got.saturation_out !== want.saturation_out)
                report($sformatf("%s saturation %0d, want %0d", tag, got.saturation_out,
                                 want.saturation_out));
            if (got.value_out !== want.value_out)
                report($sformatf("%s value %0d, want %0d", tag, got.value_out, want.value_out));
            if (got.alpha_out !== want.alpha_out)
                report($sformatf("%s alpha %0d, want %0d", tag, got.alpha_out, want.alpha_out));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       rgb_valid;
    logic       rgb_stall;
    rgb_pixel_t rgb;
    logic       hsv_valid;
    logic       hsv_stall;
    hsv_pixel_t hsv;

    hsv_scoreboard sb;
    int            accepted_in;
    int            idle_cycles;
    bit            steady;      // no idling on either side
    bit            hold_done;

    // Directed pixels, packed as red, green, blue, alpha bytes
    logic [31:0] directed_set [DIRECTED_COUNT] = '{
        32'h00000000,   // black, alpha low
        32'hFFFFFFFF,   // white, alpha high
        32'h8080804D,   // mid grey
        32'h010101_80,  // darkest non-black grey
        32'hFF0000FF,   // pure red
        32'h00FF0000,   // pure green
        32'h0000FFAA,   // pure blue
        32'hFF000A01,   // red sector, negative hue wraps
        32'hFF000102,   // red sector, smallest negative hue
        32'hC8643203,   // red sector, positive hue
        32'hFFFF0004,   // red and green tie at max
        32'hFF00FF05,   // red and blue tie at max
        32'h00FFFF06,   // green and blue tie at max
        32'h28C80A07,   // green sector, blue below red
        32'h0AC82808,   // green sector, blue above red
        32'h3214F009,   // blue sector, red above green
        32'h1432F00A,   // blue sector, red below green
        32'h0100000B,   // one-step red
        32'h0001000C,   // one-step green
        32'h0000010D,   // one-step blue
        32'hFFFEFE0E    // near-white, smallest spread
    };

    rgb_to_hsv_convert DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .hsv       (hsv)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // 0, 1, 254 or 255
    function automatic logic [COMP_W-1:0] pick_extreme();
        logic [1:0] sel;
        sel = 2'($urandom_range(0, 3));
        return {{(COMP_W-1){sel[1]}}, sel[0]};
    endfunction

    // Mostly uniform pixels, plus near-greys, component ties and full-scale corners
    function automatic rgb_pixel_t random_pixel();
        rgb_pixel_t p;
        int         kind;
        p    = rgb_pixel_t'($urandom);
        kind = $urandom_range(0, 9);
        if (kind == 6 || kind == 7)
        begin
            p.green_in = p.red_in ^ COMP_W'($urandom_range(0, 3));
            p.blue_in  = p.red_in ^ COMP_W'($urandom_range(0, 3));
        end
        else if (kind == 8)
        begin
            case ($urandom_range(0, 2))
                0:       p.green_in = p.red_in;
                1:       p.blue_in  = p.red_in;
                default: p.blue_in  = p.green_in;
            endcase
        end
        else if (kind == 9)
        begin
            p.red_in   = pick_extreme();
            p.green_in = pick_extreme();
            p.blue_in  = pick_extreme();
        end
        return p;
    endfunction

    // Offer one request and hold it until accepted; starts and ends on a falling edge
    task automatic send_pixel(input rgb_pixel_t p);
        rgb       <= p;
        rgb_valid <= 1'b1;
        do
            @(posedge clk);
        while (rgb_stall);
        @(negedge clk);
    endtask

    // Random idle gaps before about 8 in a hundred pixels, none in the steady stretch
    task automatic sender_gap();
        if (!steady && $urandom_range(0, 99) < 8)
        begin
            rgb_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    // Stop offering until every expected pixel has come out
    task automatic drain_pipe();
        rgb_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Stimulus
    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        rgb_valid = 1'b0;
        rgb       = '0;
        steady    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_pixel(rgb_pixel_t'(directed_set[i]));
        drain_pipe();

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            steady = (i >= 450 && i < 650);
            if (i == 800)
                drain_pipe();
            sender_gap();
            send_pixel(random_pixel());
        end

        drain_pipe();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d pixels (%0d directed): %0d grey, %0d red, %0d green, %0d blue",
                 sb.checked, DIRECTED_COUNT, sb.grey_hits, sb.sector_hits[SECTOR_RED],
                 sb.sector_hits[SECTOR_GREEN], sb.sector_hits[SECTOR_BLUE]);
        $display("Random stalls, one %0d-cycle output hold-off, three drains; %0d mismatches",
                 HOLD_CYCLES, sb.errors);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver stall: random, none in the steady stretch, and one long hold-off
    initial
    begin
        hsv_stall = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && accepted_in >= 250)
            begin
                hsv_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                hsv_stall <= !steady && ($urandom_range(0, 99) < 16);
            end
        end
    end

    // Monitor and watchdog, sampled at the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            if (rgb_valid && !rgb_stall)
            begin
                sb.note_pixel(rgb);
                accepted_in++;
            end
            if (hsv_valid && !hsv_stall)
                sb.check_pixel(hsv);
            if ((rgb_valid && !rgb_stall) || (hsv_valid && !hsv_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no request accepted for %0d cycles, %0d pixels outstanding",
                         IDLE_LIMIT, sb.pending());
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
